>>> hdl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared constants, types and helpers of the magnetometer range calibrator.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 14;

  // Quotient bits produced by the serial divider; larger quotients saturate.
  localparam int Q_W   = 17;
  // Dividend is |m - min| scaled by 2^(FRAC_BITS+1).
  localparam int NUM_W = 16 + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(Q_W);

  localparam logic signed [15:0] TOP_VAL = 16'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [18:0] ONE_Q   = 19'(1 << FRAC_BITS);
  localparam logic signed [18:0] SAT_HI  = 19'(32767);
  localparam logic signed [18:0] SAT_LO  = -19'sd32768;

  localparam logic CFG_MIN_SAMPLES    = 1'b0;
  localparam logic CFG_SPAN_THRESHOLD = 1'b1;

  localparam logic [15:0] MIN_SAMPLES_RST    = 16'd100;
  localparam logic [17:0] SPAN_THRESHOLD_RST = 18'd1000;

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [15:0]        mag;
    logic signed [16:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] norm;
  } div_rsp_t;

  function automatic logic signed [15:0] sext_sample(input logic [15:0] raw);
    sext_sample = 16'($signed(raw[SAMPLE_BITS-1:0]));
  endfunction

endpackage

>>> hdl/mrc_div.sv
// ----------------------------------------------------------------------------
// mrc_div
// Bit-serial restoring divider that turns one axis offset into a saturated
// Q2.14 normalized value, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrc_div import mrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } dv_state_e;

  dv_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      rem_q, rem_d;
  logic [Q_W-1:0]   sh_q, sh_d;     // dividend bits in, quotient bits out
  logic [15:0]      den_q, den_d;
  logic             neg_q, neg_d;
  logic             ovf_q, ovf_d;
  logic             zero_q, zero_d;

  logic [NUM_W-1:0]  num_full;
  logic [16:0]       trial;
  logic              fits;
  logic signed [18:0] q_signed;
  logic signed [18:0] res;
  logic signed [15:0] norm;

  assign num_full = {req_i.mag, {(FRAC_BITS + 1){1'b0}}};
  assign trial    = {rem_q, sh_q[Q_W-1]};
  assign fits     = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    den_d   = den_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    zero_d  = zero_q;
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          rem_d   = 16'(num_full >> Q_W);
          sh_d    = num_full[Q_W-1:0];
          den_d   = req_i.den[15:0];
          neg_d   = req_i.neg;
          zero_d  = req_i.den <= 17'sd0;
          // quotient of 2^Q_W or more: always saturates
          ovf_d   = 17'(num_full >> Q_W) >= 17'(req_i.den[15:0]);
          cnt_d   = CNT_W'(Q_W - 1);
          state_d = DV_RUN;
        end
      end
      DV_RUN: begin
        rem_d = fits ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        sh_d  = {sh_q[Q_W-2:0], fits};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = DV_FIN;
        end
      end
      DV_FIN: begin
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_comb begin
    q_signed = neg_q ? -$signed({2'b00, sh_q}) : $signed({2'b00, sh_q});
    res      = q_signed - ONE_Q;
    if (zero_q) begin
      norm = '0;
    end else if (ovf_q) begin
      norm = neg_q ? 16'(SAT_LO) : 16'(SAT_HI);
    end else if (res > SAT_HI) begin
      norm = 16'(SAT_HI);
    end else if (res < SAT_LO) begin
      norm = 16'(SAT_LO);
    end else begin
      norm = res[15:0];
    end
  end

  assign rsp_o.done = state_q == DV_FIN;
  assign rsp_o.norm = norm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
    zero_q <= zero_d;
  end

endmodule

>>> hdl/magnetometer_range_calibrator_core.sv
// ----------------------------------------------------------------------------
// magnetometer_range_calibrator_core
// Min/max calibration of a three-axis magnetometer with Q2.14 normalization.
// ----------------------------------------------------------------------------
// Input channel: one sample per transfer (mag_x/y/z, start_calibration),
// taken when in_valid_i is high and in_stall_o is low. Output channel: one
// result per sample (calibrating, calibrated, norm_x/y/z, span_sum), taken
// when out_valid_o is high and out_stall_i is low.
// One sample is worked on at a time. Bounds update (only while calibrating)
// and span sum walk the axes one per cycle, then a check step decides; the
// finishing sample also walks the axes to widen any collapsed axis. Once
// calibrated, each axis goes through the bit-serial divider in turn, and the
// next sample is taken once the result is loaded.
// The result sits in an output register, so a stalled receiver holds only
// that register; the next sample is taken meanwhile and waits in the final
// load step until the register is free.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) is to be written by the
// user only while idle; the block itself does not enforce this. Reset sets
// bounds to +/-32767, clears count and flags, loads register defaults
// (min_samples 100, span_threshold 1000) and empties the output.
// ----------------------------------------------------------------------------
module magnetometer_range_calibrator_core import mrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        mag_x_i,
  input  logic [15:0]        mag_y_i,
  input  logic [15:0]        mag_z_i,
  input  logic               start_calibration_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               calibrating_o,
  output logic               calibrated_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic signed [18:0] span_sum_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [17:0]        cfg_wdata_i
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_UPD   = 8'b0000_0010,
    S_ACC   = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_WID   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DWAIT = 8'b0100_0000,
    S_LOAD  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [1:0]  axis_q, axis_d;
  logic [15:0] min_samples_q;
  logic [17:0] span_thr_q;
  logic [15:0] count_q, count_d;
  logic        run_q, run_d;
  logic        done_q, done_d;

  logic signed [15:0] m_q   [3];
  logic signed [15:0] m_d   [3];
  logic signed [15:0] min_q [3];
  logic signed [15:0] min_d [3];
  logic signed [15:0] max_q [3];
  logic signed [15:0] max_d [3];
  logic signed [15:0] norm_q [3];
  logic signed [15:0] norm_d [3];
  logic signed [18:0] sum_q, sum_d;

  logic               ov_q, ov_d;
  logic               ov_run_q, ov_run_d;
  logic               ov_done_q, ov_done_d;
  logic signed [15:0] ov_norm_q [3];
  logic signed [15:0] ov_norm_d [3];
  logic signed [18:0] ov_sum_q, ov_sum_d;

  logic               in_xfer;
  logic signed [15:0] m_a, min_a, max_a;
  logic signed [16:0] diff, span;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign in_xfer = in_valid_i && (state_q == S_IDLE);
  assign m_a     = m_q[axis_q];
  assign min_a   = min_q[axis_q];
  assign max_a   = max_q[axis_q];
  assign diff    = $signed({m_a[15], m_a}) - $signed({min_a[15], min_a});
  assign span    = $signed({max_a[15], max_a}) - $signed({min_a[15], min_a});

  assign div_req.start = state_q == S_DIV;
  assign div_req.neg   = diff < 17'sd0;
  assign div_req.mag   = (diff < 17'sd0) ? 16'(-diff) : 16'(diff);
  assign div_req.den   = span;

  mrc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    count_d   = count_q;
    run_d     = run_q;
    done_d    = done_q;
    m_d       = m_q;
    min_d     = min_q;
    max_d     = max_q;
    norm_d    = norm_q;
    sum_d     = sum_q;
    ov_d      = ov_q && out_stall_i;
    ov_run_d  = ov_run_q;
    ov_done_d = ov_done_q;
    ov_norm_d = ov_norm_q;
    ov_sum_d  = ov_sum_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          m_d[0] = sext_sample(mag_x_i);
          m_d[1] = sext_sample(mag_y_i);
          m_d[2] = sext_sample(mag_z_i);
          axis_d = 2'd0;
          sum_d  = '0;
          if (start_calibration_i) begin
            count_d = '0;
            run_d   = 1'b1;
            done_d  = 1'b0;
          end
          state_d = (start_calibration_i || run_q) ? S_UPD : S_ACC;
        end
      end
      S_UPD: begin
        if (m_a < min_a) begin
          min_d[axis_q] = m_a;
        end
        if (m_a > max_a) begin
          max_d[axis_q] = m_a;
        end
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          if (count_q != 16'hFFFF) begin
            count_d = count_q + 16'd1;
          end
          axis_d  = 2'd0;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d  = sum_q + 19'(span);
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (run_q && count_q >= min_samples_q && sum_q >= $signed({1'b0, span_thr_q})) begin
          run_d   = 1'b0;
          done_d  = 1'b1;
          state_d = S_WID;
        end else if (done_q) begin
          state_d = S_DIV;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_WID: begin
        // widen a collapsed axis, downward at the top of range
        if (max_a == min_a) begin
          if (min_a >= TOP_VAL) begin
            min_d[axis_q] = max_a - 16'sd1;
          end else begin
            max_d[axis_q] = min_a + 16'sd1;
          end
          sum_d = sum_q + 19'sd1;
        end
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          norm_d[axis_q] = div_rsp.norm;
          axis_d         = axis_q + 2'd1;
          state_d        = S_DIV;
          if (axis_q == 2'd2) begin
            axis_d  = 2'd0;
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        if (!ov_q || !out_stall_i) begin
          ov_d      = 1'b1;
          ov_run_d  = run_q;
          ov_done_d = done_q;
          ov_sum_d  = sum_q;
          for (int i = 0; i < 3; i++) begin
            ov_norm_d[i] = done_q ? norm_q[i] : 16'sd0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      axis_q        <= '0;
      count_q       <= '0;
      run_q         <= 1'b0;
      done_q        <= 1'b0;
      ov_q          <= 1'b0;
      min_samples_q <= MIN_SAMPLES_RST;
      span_thr_q    <= SPAN_THRESHOLD_RST;
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= TOP_VAL;
        max_q[i] <= -TOP_VAL;
      end
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      count_q <= count_d;
      run_q   <= run_d;
      done_q  <= done_d;
      ov_q    <= ov_d;
      min_q   <= min_d;
      max_q   <= max_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_SAMPLES:    min_samples_q <= cfg_wdata_i[15:0];
          CFG_SPAN_THRESHOLD: span_thr_q    <= cfg_wdata_i;
          default:            span_thr_q    <= span_thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q       <= m_d;
    norm_q    <= norm_d;
    sum_q     <= sum_d;
    ov_run_q  <= ov_run_d;
    ov_done_q <= ov_done_d;
    ov_norm_q <= ov_norm_d;
    ov_sum_q  <= ov_sum_d;
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = ov_q;
  assign calibrating_o = ov_run_q;
  assign calibrated_o  = ov_done_q;
  assign norm_x_o      = ov_norm_q[0];
  assign norm_y_o      = ov_norm_q[1];
  assign norm_z_o      = ov_norm_q[2];
  assign span_sum_o    = ov_sum_q;

endmodule

>>> hdl/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_port_checks
// Port-level checks of the magnetometer range calibrator, bound to the core.
// ----------------------------------------------------------------------------
module mrc_port_checks (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               calibrating_o,
  input logic               calibrated_o,
  input logic signed [15:0] norm_x_o,
  input logic signed [15:0] norm_y_o,
  input logic signed [15:0] norm_z_o,
  input logic signed [18:0] span_sum_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(span_sum_o))
    else $error("stalled result dropped or changed");

  // busy after every input transfer
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a sample is in work");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(calibrating_o && calibrated_o))
    else $error("calibrating and calibrated both set");

  a_norm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !calibrated_o |-> norm_x_o == 16'sd0 && norm_y_o == 16'sd0 &&
      norm_z_o == 16'sd0)
    else $error("normalized value while not calibrated");

  a_span_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibrated_o |-> span_sum_o > 19'sd0)
    else $error("calibrated with non-positive span");

endmodule

bind magnetometer_range_calibrator_core mrc_port_checks u_mrc_checker (.*);

>>> verif/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker
// Watches the sample and result channels of the range calibrator, keeps its
// own copy of the bounds, counter, flags and registers, predicts one result
// per sample transfer and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module mrc_checker import mrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [15:0]        mag_x_i,
  input  logic [15:0]        mag_y_i,
  input  logic [15:0]        mag_z_i,
  input  logic               start_calibration_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               calibrating_i,
  input  logic               calibrated_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic signed [18:0] span_sum_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [17:0]        cfg_wdata_i,
  output int                 mismatch_cnt_o,
  output int                 pending_o,
  output int                 taken_o,
  output int                 finished_o,
  output int                 saturated_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_TOP = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int COUNT_MAX  = 65535;

  typedef struct packed {
    logic               calibrating;
    logic               calibrated;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [18:0] span_sum;
  } cal_result_t;

  cal_result_t expected_q[$];
  cal_result_t want;

  int          lo_bound[3];
  int          hi_bound[3];
  int          sample_cnt;
  logic        running;
  logic        done;
  logic [15:0] min_samples_q;
  logic [17:0] span_thr_q;

  int mismatches;
  int results;
  int taken;
  int finished;
  int saturated;

  function automatic int bounds_span();
    int s;
    s = 0;
    for (int i = 0; i < 3; i++) s += hi_bound[i] - lo_bound[i];
    return s;
  endfunction

  // 2*(m-lo)/(hi-lo)-1 in Q2.FRAC_BITS, quotient truncated toward zero
  function automatic logic signed [15:0] scale_axis(input int m, input int lo, input int hi);
    longint den;
    longint q;
    den = longint'(hi) - longint'(lo);
    if (den <= 0) return '0;
    q = (longint'(m) - longint'(lo)) * 2 * (longint'(1) << FRAC_BITS) / den
        - (longint'(1) << FRAC_BITS);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic cal_result_t step_calibration(input logic [15:0] raw_x,
                                                   input logic [15:0] raw_y,
                                                   input logic [15:0] raw_z,
                                                   input logic start);
    int                 m[3];
    logic signed [15:0] n[3];
    cal_result_t        r;
    m[0] = $signed(raw_x[SAMPLE_BITS-1:0]);
    m[1] = $signed(raw_y[SAMPLE_BITS-1:0]);
    m[2] = $signed(raw_z[SAMPLE_BITS-1:0]);
    if (start) begin
      sample_cnt = 0;
      running    = 1'b1;
      done       = 1'b0;
    end
    if (running) begin
      for (int i = 0; i < 3; i++) begin
        if (m[i] < lo_bound[i]) lo_bound[i] = m[i];
        if (m[i] > hi_bound[i]) hi_bound[i] = m[i];
      end
      if (sample_cnt < COUNT_MAX) sample_cnt++;
      if (sample_cnt >= int'(min_samples_q) && bounds_span() >= int'(span_thr_q)) begin
        // widen a zero span; at the top of range lower the minimum instead
        for (int i = 0; i < 3; i++) begin
          if (hi_bound[i] == lo_bound[i]) begin
            if (lo_bound[i] >= SAMPLE_TOP) lo_bound[i] = hi_bound[i] - 1;
            else hi_bound[i] = lo_bound[i] + 1;
          end
        end
        running = 1'b0;
        done    = 1'b1;
        finished++;
      end
    end
    for (int i = 0; i < 3; i++) begin
      n[i] = done ? scale_axis(m[i], lo_bound[i], hi_bound[i]) : 16'sd0;
      if (done && (n[i] == 16'sh7FFF || n[i] == 16'sh8000)) saturated++;
    end
    r.calibrating = running;
    r.calibrated  = done;
    r.norm_x      = n[0];
    r.norm_y      = n[1];
    r.norm_z      = n[2];
    r.span_sum    = 19'(bounds_span());
    return r;
  endfunction

  task automatic flag_field(input string what, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", results, what, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lo_bound[i] = SAMPLE_TOP;
        hi_bound[i] = -SAMPLE_TOP;
      end
      sample_cnt    = 0;
      running       = 1'b0;
      done          = 1'b0;
      min_samples_q = MIN_SAMPLES_RST;
      span_thr_q    = SPAN_THRESHOLD_RST;
      mismatches    = 0;
      results       = 0;
      taken         = 0;
      finished      = 0;
      saturated     = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MIN_SAMPLES) min_samples_q = cfg_wdata_i[15:0];
        else span_thr_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(step_calibration(mag_x_i, mag_y_i, mag_z_i,
                                              start_calibration_i));
        taken++;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: transfer with nothing expected", results);
        end else begin
          want = expected_q.pop_front();
          flag_field("calibrating", want.calibrating, calibrating_i);
          flag_field("calibrated", want.calibrated, calibrated_i);
          flag_field("norm_x", want.norm_x, norm_x_i);
          flag_field("norm_y", want.norm_y, norm_y_i);
          flag_field("norm_z", want.norm_z, norm_z_i);
          flag_field("span_sum", want.span_sum, span_sum_i);
        end
        results++;
      end
    end
    mismatch_cnt_o <= mismatches;
    pending_o      <= expected_q.size();
    taken_o        <= taken;
    finished_o     <= finished;
    saturated_o    <= saturated;
  end

endmodule

>>> verif/tb_magnetometer_range_calibrator_core.sv
// ----------------------------------------------------------------------------
// tb_magnetometer_range_calibrator_core
// Drives samples, register writes and receiver stalls into the calibrator;
// a directed opening and random sequences under four idling mixes.
// Checking is done by mrc_checker.
// ----------------------------------------------------------------------------
module tb_magnetometer_range_calibrator_core import mrc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 100;

  logic               clk_i;
  logic               rst_ni              = 1'b0;
  logic               in_valid_i          = 1'b0;
  logic               in_stall_o;
  logic [15:0]        mag_x_i             = '0;
  logic [15:0]        mag_y_i             = '0;
  logic [15:0]        mag_z_i             = '0;
  logic               start_calibration_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i         = 1'b0;
  logic               calibrating_o;
  logic               calibrated_o;
  logic signed [15:0] norm_x_o;
  logic signed [15:0] norm_y_o;
  logic signed [15:0] norm_z_o;
  logic signed [18:0] span_sum_o;
  logic               cfg_we_i            = 1'b0;
  logic               cfg_index_i         = CFG_MIN_SAMPLES;
  logic [17:0]        cfg_wdata_i         = '0;

  int mismatch_cnt;
  int pending;
  int taken;
  int finished;
  int saturated;

  int  idle_pct    = 0;
  int  stall_pct   = 0;
  int  hold_at     = -1;
  bit  hold_done   = 1'b0;
  int  quiet_cycles = 0;

  magnetometer_range_calibrator_core DUT (.*);

  mrc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i (in_stall_o),
    .mag_x_i, .mag_y_i, .mag_z_i, .start_calibration_i,
    .out_valid_i (out_valid_o),
    .out_stall_i,
    .calibrating_i (calibrating_o),
    .calibrated_i  (calibrated_o),
    .norm_x_i      (norm_x_o),
    .norm_y_i      (norm_y_o),
    .norm_z_i      (norm_z_o),
    .span_sum_i    (span_sum_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .taken_o        (taken),
    .finished_o     (finished),
    .saturated_o    (saturated)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && taken == hold_at) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] z, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    mag_x_i             <= x;
    mag_y_i             <= y;
    mag_z_i             <= z;
    start_calibration_i <= start;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [17:0] val);
    wait_drained(16);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int         cur_min;
    int         items;
    int         seq_len;
    logic [17:0] thr;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset: nothing calibrated yet
    send_item(16'h0000, 16'h0000, 16'h0000, 1'b0);
    write_reg(CFG_MIN_SAMPLES, 18'd2);
    write_reg(CFG_SPAN_THRESHOLD, 18'd0);
    // zero spans on every axis, z sitting at the top of the range
    send_item(16'd5, 16'h8000, 16'h7FFF, 1'b1);
    send_item(16'd5, 16'h8000, 16'h7FFF, 1'b0);
    // calibrated, far outside the bounds: saturate both ways
    send_item(16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
    send_item(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
    send_item(16'hFFFF, 16'h8001, 16'h7FFE, 1'b0);
    send_item(16'd6, 16'h5555, 16'hAAAA, 1'b0);
    // restart while calibrated, then again while still running
    send_item(16'd100, 16'(-100), 16'd1000, 1'b1);
    send_item(16'(-100), 16'd200, 16'd2000, 1'b1);
    send_item(16'd50, 16'd50, 16'd50, 1'b0);
    send_item(16'(-40), 16'd77, 16'd3000, 1'b0);
    send_item(16'd0, 16'd0, 16'd0, 1'b0);
    // with no sample minimum the start transfer finishes by itself
    write_reg(CFG_MIN_SAMPLES, 18'd0);
    send_item(16'd0, 16'd0, 16'd0, 1'b1);
    send_item(16'd20, 16'(-20), 16'd500, 1'b0);

    // random sequences: mostly start plus a run of samples, some noise
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      case ($urandom_range(3))
        0:       cur_min = 0;
        1:       cur_min = 1;
        default: cur_min = $urandom_range(24, 2);
      endcase
      case ($urandom_range(3))
        0:       thr = 18'd0;
        1:       thr = 18'd196605;
        default: thr = 18'($urandom_range(196605));
      endcase
      write_reg(CFG_MIN_SAMPLES, 18'(cur_min));
      write_reg(CFG_SPAN_THRESHOLD, thr);
      if (phase == 0) hold_at = taken + 20;
      items = 0;
      while (items < PHASE_ITEMS) begin
        if ($urandom_range(4) != 0) begin
          seq_len = $urandom_range(cur_min + 8);
          send_item(pick_sample(), pick_sample(), pick_sample(), 1'b1);
          items++;
          repeat (seq_len) begin
            send_item(pick_sample(), pick_sample(), pick_sample(), 1'b0);
            items++;
          end
        end else begin
          repeat ($urandom_range(5, 1)) begin
            send_item(pick_sample(), pick_sample(), pick_sample(),
                      $urandom_range(2) == 0);
            items++;
          end
        end
      end
    end

    wait_drained(100);
    $display("Covered %0d samples: %0d calibrations finished, %0d normalized values saturated",
             taken, finished, saturated);
    if (mismatch_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
hdl/mrc_pkg.sv
hdl/mrc_div.sv
hdl/magnetometer_range_calibrator_core.sv
hdl/mrc_checker.sv
verif/mrc_checker.sv
verif/tb_magnetometer_range_calibrator_core.sv
